@@ hdl/sorted_priority_queue_defines.svh @@
// assertion macros for the sorted priority queue
// no dependencies; included by files that carry concurrent checks
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sorted priority queue check failed");
// condition must never be true outside reset
`define SPQ_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sorted priority queue forbidden condition");
`else
`define SPQ_ASSERT(label, clk, rst, prop)
`define SPQ_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

@@ hdl/spq_pkg.sv @@
// shared types, constants and helpers of the sorted priority queue
// no dependencies; used by spq_ram users and the top level
package spq_pkg;

   // queue size and derived widths
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   // field widths
   localparam int TAG_W  = 16;
   localparam int FARE_W = 24;
   localparam int PTS_W  = 20;
   localparam int KEY_W  = 27;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   // key = fare + 100 * points
   localparam int PTS_SCALE = 100;

   // stream widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [TAG_W-1:0]  tag_type;
   typedef logic [FARE_W-1:0] fare_type;
   typedef logic [PTS_W-1:0]  pts_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [OCC_W-1:0]  occ_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_REMOVE = 1'b1
   } action_type;

   // one stored entry, key kept alongside so a scan step is a single compare
   typedef struct packed {
      key_type  key;
      pts_type  pts;
      fare_type fare;
      tag_type  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // circular index: sum of head and offset is always below twice the depth
   function automatic idx_type wrap_idx(sum_type a);
      if (a >= sum_type'(DEPTH)) begin
         return idx_type'(a - sum_type'(DEPTH));
      end
      return idx_type'(a);
   endfunction

endpackage

@@ hdl/sorted_priority_queue.sv @@
// sorted priority queue, uses spq_pkg and spq_ram: entries ascending by fare + 100 * points
// a remove reads the head entry; a full insert or empty remove responds straight away;
// an insert scans down from the tail moving each larger-key entry up one slot, then writes
// itself into the freed slot; one request at a time, the next is accepted the cycle after the
// result is loaded into the output register, which waits while a held response blocks it
// synchronous active-high reset empties the queue; ram contents are not cleared
module sorted_priority_queue (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tag[15:0], fare_cents[39:16], points[59:40], zero pad
   input  logic [spq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,  // action
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_tag[15:0], out_fare_cents[39:16], out_points[59:40], occupancy[64:60], zero pad
   output logic [spq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser   // status
);

`include "sorted_priority_queue_defines.svh"

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_START   = 7'b0000010,
      ST_INS_RD  = 7'b0000100,
      ST_INS_CMP = 7'b0001000,
      ST_RM_RD   = 7'b0010000,
      ST_RM_CAP  = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   spq_pkg::cnt_type                count_ff, count_in;
   spq_pkg::idx_type                head_ff, head_in;
   spq_pkg::cnt_type                pos_ff, pos_in;
   spq_pkg::entry_type              new_ff, new_in;
   logic                            action_ff, action_in;
   spq_pkg::status_type             status_ff, status_in;
   spq_pkg::tag_type                otag_ff, otag_in;
   spq_pkg::fare_type               ofare_ff, ofare_in;
   spq_pkg::pts_type                opts_ff, opts_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]                      rsp_user_ff, rsp_user_in;

   logic                    ram_wr_en;
   spq_pkg::idx_type        ram_wr_addr;
   spq_pkg::entry_type      ram_wr_data;
   logic                    ram_rd_en;
   spq_pkg::idx_type        ram_rd_addr;
   spq_pkg::entry_type      ram_rd_data;
   spq_pkg::idx_type        addr_at_pos;
   spq_pkg::idx_type        addr_below_pos;
   logic                    req_accept;
   logic                    slot_free;

   // entry store
   spq_ram #(
      .WIDTH (spq_pkg::ENTRY_W),
      .DEPTH (spq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // ram slots at the scan position and just below it
   assign addr_at_pos = spq_pkg::wrap_idx(spq_pkg::sum_type'(head_ff)
                                          + spq_pkg::sum_type'(pos_ff));
   assign addr_below_pos = spq_pkg::wrap_idx(spq_pkg::sum_type'(head_ff)
                                             + spq_pkg::sum_type'(pos_ff)
                                             - spq_pkg::sum_type'(1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      new_in       = new_ff;
      action_in    = action_ff;
      status_in    = status_ff;
      otag_in      = otag_ff;
      ofare_in     = ofare_ff;
      opts_in      = opts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_at_pos;
      ram_wr_data  = new_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_below_pos;

      // response register drains independently
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in   = req_tuser;
               new_in.tag  = req_tdata[15:0];
               new_in.fare = req_tdata[39:16];
               new_in.pts  = req_tdata[59:40];
               new_in.key  = '0;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            // key computed once per request; removed-entry fields default to zero
            new_in.key = spq_pkg::key_type'(new_ff.fare)
                       + spq_pkg::key_type'(new_ff.pts)
                       * spq_pkg::key_type'(spq_pkg::PTS_SCALE);
            otag_in  = '0;
            ofare_in = '0;
            opts_in  = '0;
            pos_in   = count_ff;
            if (action_ff == spq_pkg::ACTION_INSERT) begin
               if (count_ff >= spq_pkg::cnt_type'(spq_pkg::DEPTH)) begin
                  status_in = spq_pkg::STATUS_FULL;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_INS_RD;
               end
            end else begin
               if (count_ff == '0) begin
                  status_in = spq_pkg::STATUS_EMPTY;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_RM_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               // reached the front: place the new entry at the head
               ram_wr_en = 1'b1;
               count_in  = count_ff + spq_pkg::cnt_type'(1);
               status_in = spq_pkg::STATUS_INSERTED;
               state_in  = ST_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data.key > new_ff.key) begin
               // larger key moves up one slot, keep scanning down
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - spq_pkg::cnt_type'(1);
               state_in    = ST_INS_RD;
            end else begin
               // equal or smaller key stays ahead of the new entry
               count_in  = count_ff + spq_pkg::cnt_type'(1);
               status_in = spq_pkg::STATUS_INSERTED;
               state_in  = ST_DONE;
            end
         end
         ST_RM_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = head_ff;
            state_in    = ST_RM_CAP;
         end
         ST_RM_CAP: begin
            otag_in   = ram_rd_data.tag;
            ofare_in  = ram_rd_data.fare;
            opts_in   = ram_rd_data.pts;
            head_in   = spq_pkg::wrap_idx(spq_pkg::sum_type'(head_ff)
                                          + spq_pkg::sum_type'(1));
            count_in  = count_ff - spq_pkg::cnt_type'(1);
            status_in = spq_pkg::STATUS_REMOVED;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {7'b0, spq_pkg::occ_type'(count_ff), opts_ff, ofare_ff, otag_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      new_ff      <= new_in;
      action_ff   <= action_in;
      status_ff   <= status_in;
      otag_ff     <= otag_in;
      ofare_ff    <= ofare_in;
      opts_ff     <= opts_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `SPQ_ASSERT_NEVER(a_count_max, clock, reset, count_ff > spq_pkg::cnt_type'(spq_pkg::DEPTH))
   `SPQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
   `SPQ_ASSERT(a_scan_nonzero, clock, reset, (state_ff == ST_INS_CMP) |-> (pos_ff != '0))
   `SPQ_ASSERT(a_pop_count, clock, reset, (state_ff == ST_RM_CAP) |=> (count_ff < $past(count_ff)))

endmodule

@@ hdl/spq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
